/* rtl/core/cgsl_pkg.sv */
// Shared types and constants of the charge gate safety latch.
package cgsl_pkg;

    // Event codes carried in the action field
    localparam logic [2:0] ACT_ENABLE  = 3'd0;
    localparam logic [2:0] ACT_DISABLE = 3'd1;
    localparam logic [2:0] ACT_REPORT  = 3'd2;
    localparam logic [2:0] ACT_TICK    = 3'd3;
    localparam logic [2:0] ACT_REINIT  = 3'd4;

    // Trip reason codes
    localparam logic [1:0] REASON_OK   = 2'd0;
    localparam logic [1:0] REASON_OV   = 2'd1;
    localparam logic [1:0] REASON_TIME = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACK_MV      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SESSION_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSE_OK_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSE_OK_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSE_PRESENT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_ACTIVE_HIGH = 3'd5;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_ms;
        logic [15:0] pack_mv;
        logic [11:0] sense_adc;
    } evt_item_t;

    typedef struct packed {
        logic        gate_level;
        logic        charging_on;
        logic        locked_out;
        logic [1:0]  trip_reason;
        logic [31:0] elapsed_ms;
    } res_item_t;

    typedef struct packed {
        logic [15:0] max_pack_mv;
        logic [31:0] max_session_ms;
        logic [11:0] sense_ok_min;
        logic [11:0] sense_ok_max;
        logic        sense_present;
        logic        gate_active_high;
    } cfg_t;

    typedef struct packed {
        logic        gate_on;
        logic        safety_lock;
        logic [1:0]  reason_code;
        logic [15:0] last_pack_mv;
        logic [31:0] session_start_ms;
        logic        session_timer_valid;
    } state_t;

    localparam cfg_t CFG_RESET = '{
        max_pack_mv:      16'd12600,
        max_session_ms:   32'd7200000,
        sense_ok_min:     12'd0,
        sense_ok_max:     12'd4095,
        sense_present:    1'b0,
        gate_active_high: 1'b1
    };

    localparam state_t STATE_RESET = '{
        gate_on:             1'b0,
        safety_lock:         1'b0,
        reason_code:         REASON_OK,
        last_pack_mv:        16'd0,
        session_start_ms:    32'd0,
        session_timer_valid: 1'b0
    };

endpackage

/* rtl/core/cgsl_stream_if.sv */
// Valid/ready stream interface carrying one item of a given payload type.
interface cgsl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/cgsl_event_core.sv */
// Next-state and result logic for one event of the charge gate latch.
module cgsl_event_core (
    input  cgsl_pkg::state_t    cur,
    input  cgsl_pkg::cfg_t      cfg,
    input  cgsl_pkg::evt_item_t item,
    output cgsl_pkg::state_t    nxt,
    output cgsl_pkg::res_item_t res
);
    import cgsl_pkg::*;

    logic [31:0] diff_ms;
    logic        last_ov;
    logic        sense_bad;
    logic        started;

    assign diff_ms   = item.now_ms - cur.session_start_ms;
    assign last_ov   = (cur.last_pack_mv >= cfg.max_pack_mv);
    assign sense_bad = cfg.sense_present &&
                       ((item.sense_adc < cfg.sense_ok_min) ||
                        (item.sense_adc > cfg.sense_ok_max));

    always_comb
    begin
        nxt     = cur;
        started = 1'b0;
        unique case (item.action)
            ACT_ENABLE:
            begin
                if (cur.safety_lock || sense_bad)
                begin
                    nxt.gate_on             = 1'b0;
                    nxt.session_timer_valid = 1'b0;
                end
                else if (last_ov)
                begin
                    nxt.gate_on             = 1'b0;
                    nxt.session_timer_valid = 1'b0;
                    nxt.safety_lock         = 1'b1;
                    nxt.reason_code         = REASON_OV;
                end
                else
                begin
                    if (!cur.gate_on)
                    begin
                        nxt.session_start_ms    = item.now_ms;
                        nxt.session_timer_valid = 1'b1;
                        started                 = 1'b1;
                    end
                    nxt.gate_on = 1'b1;
                end
            end
            ACT_DISABLE:
            begin
                nxt.gate_on             = 1'b0;
                nxt.session_timer_valid = 1'b0;
            end
            ACT_REPORT:
            begin
                // drop a zero report
                if (item.pack_mv != 16'd0)
                begin
                    nxt.last_pack_mv = item.pack_mv;
                    if (item.pack_mv >= cfg.max_pack_mv)
                    begin
                        nxt.gate_on             = 1'b0;
                        nxt.session_timer_valid = 1'b0;
                        nxt.safety_lock         = 1'b1;
                        nxt.reason_code         = REASON_OV;
                    end
                end
            end
            ACT_TICK:
            begin
                if (cur.gate_on)
                begin
                    if (last_ov)
                    begin
                        nxt.gate_on             = 1'b0;
                        nxt.session_timer_valid = 1'b0;
                        nxt.safety_lock         = 1'b1;
                        nxt.reason_code         = REASON_OV;
                    end
                    else if (cur.session_timer_valid && (diff_ms >= cfg.max_session_ms))
                    begin
                        nxt.gate_on             = 1'b0;
                        nxt.session_timer_valid = 1'b0;
                        nxt.safety_lock         = 1'b1;
                        nxt.reason_code         = REASON_TIME;
                    end
                end
            end
            ACT_REINIT:
            begin
                nxt = STATE_RESET;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    always_comb
    begin
        res.gate_level  = nxt.gate_on ? cfg.gate_active_high : ~cfg.gate_active_high;
        res.charging_on = nxt.gate_on;
        res.locked_out  = nxt.safety_lock;
        res.trip_reason = nxt.reason_code;
        // a session opened by this event has seen no time yet
        if (nxt.gate_on && nxt.session_timer_valid)
            res.elapsed_ms = started ? 32'd0 : diff_ms;
        else
            res.elapsed_ms = 32'd0;
    end

endmodule

/* rtl/core/charge_gate_safety_latch.sv */
// Top level of the charge gate controller with latching safety lockout.
//
// Usage:
//   evt  - sink stream of event items (action, now_ms, pack_mv, sense_adc).
//          Actions: enable request, disable, pack voltage report, tick, re-init.
//   res  - source stream of result items (gate_level, charging_on, locked_out,
//          trip_reason, elapsed_ms); exactly one result per event item.
//   cfg_we/cfg_idx/cfg_data - register write port, one write per cycle with
//          cfg_we high; indexes beyond the register list are ignored. Write
//          only while no event result is outstanding.
//
// The result is registered and shows in the cycle after its item is taken.
// Throughput, set by the single result register, is one item per cycle while
// results are taken; the state update and the 32-bit elapsed-time subtract and
// compare all sit in one combinational pass between event port and register.
// When the receiver stalls, the result holds in its register and evt.ready
// drops until it is taken; evt.ready stays high while the result drains.
// Reset clears the latch state (gate off, unlocked, reason ok, no session)
// and loads the register reset values. A tripped lock clears only on re-init or reset.
module charge_gate_safety_latch (
    input  logic                                 clk,
    input  logic                                 rst_n,
    cgsl_stream_if.sink                          evt,
    cgsl_stream_if.source                        res,
    input  logic                                 cfg_we,
    input  logic [cgsl_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [cgsl_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import cgsl_pkg::*;

    cfg_t      cfg_reg;
    state_t    state_reg;
    state_t    state_next;
    res_item_t res_reg;
    res_item_t res_next;
    logic      res_valid_reg;
    logic      evt_take;

    // Accept a new item whenever the result slot is empty or being emptied
    assign evt.ready = !res_valid_reg || res.ready;
    assign evt_take  = evt.valid && evt.ready;

    assign res.valid   = res_valid_reg;
    assign res.payload = res_reg;

    cgsl_event_core u_core (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .item (evt.payload),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Register file: write the addressed field, ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_MAX_PACK_MV:      cfg_reg.max_pack_mv      <= cfg_data[15:0];
                CFG_MAX_SESSION_MS:   cfg_reg.max_session_ms   <= cfg_data[31:0];
                CFG_SENSE_OK_MIN:     cfg_reg.sense_ok_min     <= cfg_data[11:0];
                CFG_SENSE_OK_MAX:     cfg_reg.sense_ok_max     <= cfg_data[11:0];
                CFG_SENSE_PRESENT:    cfg_reg.sense_present    <= cfg_data[0];
                CFG_GATE_ACTIVE_HIGH: cfg_reg.gate_active_high <= cfg_data[0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Advance the latch state on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (evt_take)
            state_reg <= state_next;
    end

    // Result slot: fill on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (evt_take)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    // Payload needs no reset; load with the item's result
    always_ff @(posedge clk)
    begin
        if (evt_take)
            res_reg <= res_next;
    end

endmodule

/* rtl/core/cgsl_checker.sv */
// Port-level assertions for the charge gate safety latch, bound to the top.
module cgsl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        evt_valid,
    input logic        evt_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic        gate_level,
    input logic        charging_on,
    input logic        locked_out,
    input logic [1:0]  trip_reason,
    input logic [31:0] elapsed_ms
);
    import cgsl_pkg::*;

    // A stalled result holds its value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(gate_level) &&
        $stable(charging_on) && $stable(locked_out) && $stable(trip_reason) &&
        $stable(elapsed_ms))
        else $error("result changed while stalled");

    // Each accepted item yields a result in the next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> res_valid)
        else $error("no result after accepted item");

    // A latched lock always carries a reason, and only then
    a_lock_reason: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (locked_out == (trip_reason != REASON_OK)))
        else $error("lock and reason disagree");

    // A locked block never charges
    a_lock_off: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && locked_out |-> !charging_on)
        else $error("charging while locked out");

    // Elapsed time reads zero when not charging
    a_idle_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !charging_on |-> (elapsed_ms == 32'd0))
        else $error("elapsed time without a session");

endmodule

bind charge_gate_safety_latch cgsl_checker u_cgsl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt_valid   (evt.valid),
    .evt_ready   (evt.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .gate_level  (res.payload.gate_level),
    .charging_on (res.payload.charging_on),
    .locked_out  (res.payload.locked_out),
    .trip_reason (res.payload.trip_reason),
    .elapsed_ms  (res.payload.elapsed_ms)
);
